[hw/rtl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Operation codes, the multiply-accumulate command and the accumulator map.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int LIMB_W     = 32;
    localparam int ACC_LIMBS  = 8;
    localparam int ACC_W      = LIMB_W * ACC_LIMBS;
    localparam int ACC_COUNT  = 4;
    localparam int ACC_IDX_W  = 2;
    localparam int SHIFT_W    = 3;

    // limb counts of the operands (sums of 64-bit squares stay below 96 bits)
    localparam int NORM_LIMBS = 3;
    localparam int SQ_LIMBS   = 2;
    localparam int NN_LIMBS   = 6;

    localparam int BIN_W      = 32;
    localparam int SIM_W      = 17;
    localparam logic [SIM_W-1:0] SIM_ONE = 17'd65536;

    typedef logic [1:0] op_code_t;
    localparam op_code_t OP_LOAD_A  = 2'd0;
    localparam op_code_t OP_LOAD_B  = 2'd1;
    localparam op_code_t OP_COMPUTE = 2'd2;

    // accumulator slots; the first three are reused once their first value is consumed
    localparam logic [ACC_IDX_W-1:0] ACC_DOT = 2'd0;  // dot, later mid^2
    localparam logic [ACC_IDX_W-1:0] ACC_NA  = 2'd1;  // normA^2, later dot^2
    localparam logic [ACC_IDX_W-1:0] ACC_NB  = 2'd2;  // normB^2, later trial product
    localparam logic [ACC_IDX_W-1:0] ACC_NN  = 2'd3;  // normA^2 * normB^2

    typedef struct packed {
        logic                  valid;
        logic [ACC_COUNT-1:0]  clr;
        logic [ACC_IDX_W-1:0]  dst;
        logic [SHIFT_W-1:0]    shift;
        logic [LIMB_W-1:0]     x;
        logic [LIMB_W-1:0]     y;
    } bsc_mac_op_t;

    typedef logic [ACC_COUNT-1:0][ACC_W-1:0] bsc_acc_t;

endpackage

[hw/rtl/binned_spectrum_cosine_similarity.sv]
// ----------------------------------------------------------------------------
// binned_spectrum_cosine_similarity: cosine similarity of two binned spectra
// Peak loads into two bin stores; a compute transfer returns the Q16 cosine.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_tready is high only while the sequencer is
// idle. After reset a clearing pass writes zero to every bin before the first
// transfer is accepted. A peak load is accepted in idle, then each bin touched
// takes a select, a read and a saturating write, and each flank that is
// skipped takes only a select. A compute item walks every bin with three
// products through the one shared 32x32 multiplier, then forms the wide
// products normA^2 * normB^2 and dot^2 with pipeline drains, then runs a
// binary search of up to 17 steps for the Q16 result where each step uses
// the same multiplier (square, twelve limb products, two drains, compare).
// When a norm is zero the wide products and the search are skipped. A wait
// is added if the previous result has not yet been taken. The walk also
// writes zero back to both stores, so they start empty for the next round.
// ----------------------------------------------------------------------------
module binned_spectrum_cosine_similarity
    import bsc_pkg::*;
#(
    parameter int BIN_COUNT    = 4003,
    parameter int MZ_FRAC_BITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: flank_spread
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [14:0] peak_mz, [30:15] peak_intensity
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] similarity
    output logic        m_tuser    // [0] zero_norm
);

    localparam int AW = $clog2(BIN_COUNT);

    // sequencer states
    localparam logic [3:0] S_INIT   = 4'd0;   // clearing pass after reset
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LD_SEL = 4'd2;   // pick next bin of the peak
    localparam logic [3:0] S_LD_RD  = 4'd3;   // memory read in flight
    localparam logic [3:0] S_LD_WR  = 4'd4;   // saturating write back
    localparam logic [3:0] S_WALK   = 4'd5;   // dot and norms over all bins
    localparam logic [3:0] S_DRAIN  = 4'd6;   // let the last product land
    localparam logic [3:0] S_ZCHK   = 4'd7;
    localparam logic [3:0] S_NN     = 4'd8;   // normA^2 * normB^2
    localparam logic [3:0] S_DSQ    = 4'd9;   // dot^2
    localparam logic [3:0] S_SQ     = 4'd10;  // trial mid^2
    localparam logic [3:0] S_T      = 4'd11;  // mid^2 * nn
    localparam logic [3:0] S_CMP    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]        state_reg, ret_reg;
    logic              flank_reg;
    logic [AW-1:0]     addr_reg;
    logic [1:0]        sub_reg;        // walk sub-cycle
    logic [1:0]        ld_step_reg;    // 0 lower flank, 1 center, 2 upper flank
    logic              ld_b_reg;
    logic [AW-1:0]     idx_reg;
    logic [15:0]       inten_reg;
    logic [16:0]       addend_reg;
    logic [BIN_W-1:0]  a_lat_reg, b_lat_reg;
    logic [2:0]        li_reg, lj_reg;
    logic [SIM_W-1:0]  lo_reg, hi_reg, mid_reg;
    logic              zflag_reg;
    logic              m_valid_reg;
    logic [SIM_W-1:0]  m_sim_reg;
    logic              m_zero_reg;

    logic              we_a, we_b;
    logic [BIN_W-1:0]  wdata;
    logic [BIN_W-1:0]  rdata_a, rdata_b, rdata_sel;
    logic [BIN_W:0]    sat_sum;
    bsc_mac_op_t       mac_op;
    bsc_acc_t          acc;

    // peak decode
    logic [14:0]       in_mz;
    logic [15:0]       in_inten;
    logic [16:0]       in_idx;
    assign in_mz    = s_tdata[14:0];
    assign in_inten = s_tdata[30:15];
    assign in_idx   = 17'({1'b0, in_mz, 1'b0} >> MZ_FRAC_BITS);

    // binary search step
    logic [17:0]       span;
    logic [SIM_W-1:0]  mid;
    assign span = 18'(hi_reg) - 18'(lo_reg) + 18'd1;
    assign mid  = lo_reg + SIM_W'(span >> 1);

    // load target for the current step
    logic              ld_en;
    logic [AW-1:0]     ld_tgt;
    logic [16:0]       ld_add;
    always_comb begin
        ld_en  = 1'b0;
        ld_tgt = idx_reg;
        ld_add = {1'b0, inten_reg};
        case (ld_step_reg)
            2'd0: begin
                ld_en  = flank_reg && (idx_reg != '0);
                ld_tgt = idx_reg - AW'(1);
            end
            2'd1: begin
                ld_en  = 1'b1;
                ld_add = {inten_reg, 1'b0};
            end
            2'd2: begin
                ld_en  = flank_reg && ((17'(idx_reg) + 17'd1) < 17'(BIN_COUNT));
                ld_tgt = idx_reg + AW'(1);
            end
            default: begin
                ld_en = 1'b0;
            end
        endcase
    end

    assign rdata_sel = ld_b_reg ? rdata_b : rdata_a;
    assign sat_sum   = (BIN_W+1)'(rdata_sel) + (BIN_W+1)'(addend_reg);

    // limb loop end flags
    logic nn_last, sq_last, t_last;
    assign nn_last = (li_reg == 3'(NORM_LIMBS - 1)) && (lj_reg == 3'(NORM_LIMBS - 1));
    assign sq_last = nn_last;
    assign t_last  = (li_reg == 3'(SQ_LIMBS - 1)) && (lj_reg == 3'(NN_LIMBS - 1));

    logic [ACC_W-1:0] lhs;
    assign lhs = {acc[ACC_NA][ACC_W-LIMB_W-1:0], {LIMB_W{1'b0}}};

    // memory and multiplier commands
    always_comb begin
        we_a   = 1'b0;
        we_b   = 1'b0;
        wdata  = '0;
        mac_op = '0;
        case (state_reg)
            S_INIT: begin
                we_a = 1'b1;
                we_b = 1'b1;
            end
            S_IDLE: begin
                if (s_tvalid && s_tuser == OP_COMPUTE) begin
                    mac_op.clr = '1;
                end
            end
            S_LD_WR: begin
                we_a  = !ld_b_reg;
                we_b  = ld_b_reg;
                wdata = sat_sum[BIN_W] ? '1 : sat_sum[BIN_W-1:0];
            end
            S_WALK: begin
                case (sub_reg)
                    2'd1: begin
                        mac_op.valid = 1'b1;
                        mac_op.dst   = ACC_DOT;
                        mac_op.x     = rdata_a;
                        mac_op.y     = rdata_b;
                    end
                    2'd2: begin
                        mac_op.valid = 1'b1;
                        mac_op.dst   = ACC_NA;
                        mac_op.x     = a_lat_reg;
                        mac_op.y     = a_lat_reg;
                        we_a         = 1'b1;   // clear the bin behind the walk
                        we_b         = 1'b1;
                    end
                    2'd3: begin
                        mac_op.valid = 1'b1;
                        mac_op.dst   = ACC_NB;
                        mac_op.x     = b_lat_reg;
                        mac_op.y     = b_lat_reg;
                    end
                    default: begin
                        mac_op.valid = 1'b0;
                    end
                endcase
            end
            S_NN: begin
                mac_op.valid       = 1'b1;
                mac_op.clr[ACC_NN] = (li_reg == '0) && (lj_reg == '0);
                mac_op.dst         = ACC_NN;
                mac_op.shift       = SHIFT_W'(li_reg + lj_reg);
                mac_op.x           = acc[ACC_NA][li_reg*LIMB_W +: LIMB_W];
                mac_op.y           = acc[ACC_NB][lj_reg*LIMB_W +: LIMB_W];
            end
            S_DSQ: begin
                mac_op.valid       = 1'b1;
                mac_op.clr[ACC_NA] = (li_reg == '0) && (lj_reg == '0);
                mac_op.dst         = ACC_NA;
                mac_op.shift       = SHIFT_W'(li_reg + lj_reg);
                mac_op.x           = acc[ACC_DOT][li_reg*LIMB_W +: LIMB_W];
                mac_op.y           = acc[ACC_DOT][lj_reg*LIMB_W +: LIMB_W];
            end
            S_SQ: begin
                if (lo_reg != hi_reg) begin
                    mac_op.valid        = 1'b1;
                    mac_op.clr[ACC_DOT] = 1'b1;
                    mac_op.dst          = ACC_DOT;
                    mac_op.x            = LIMB_W'(mid);
                    mac_op.y            = LIMB_W'(mid);
                end
            end
            S_T: begin
                mac_op.valid       = 1'b1;
                mac_op.clr[ACC_NB] = (li_reg == '0) && (lj_reg == '0);
                mac_op.dst         = ACC_NB;
                mac_op.shift       = SHIFT_W'(li_reg + lj_reg);
                mac_op.x           = acc[ACC_DOT][li_reg*LIMB_W +: LIMB_W];
                mac_op.y           = acc[ACC_NN][lj_reg*LIMB_W +: LIMB_W];
            end
            default: begin
                mac_op = '0;
            end
        endcase
    end

    // flank_spread register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flank_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            flank_reg <= cfg_wr_data;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_OUT a taken result is replaced below
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    if (addr_reg == AW'(BIN_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        case (s_tuser)
                            OP_LOAD_A, OP_LOAD_B: begin
                                if (in_idx < 17'(BIN_COUNT)) begin
                                    ld_b_reg    <= (s_tuser == OP_LOAD_B);
                                    idx_reg     <= in_idx[AW-1:0];
                                    inten_reg   <= in_inten;
                                    ld_step_reg <= 2'd0;
                                    state_reg   <= S_LD_SEL;
                                end
                            end
                            OP_COMPUTE: begin
                                addr_reg  <= '0;
                                sub_reg   <= 2'd0;
                                state_reg <= S_WALK;
                            end
                            default: begin
                                state_reg <= S_IDLE;  // unused code: dropped
                            end
                        endcase
                    end
                end
                S_LD_SEL: begin
                    if (ld_en) begin
                        addr_reg   <= ld_tgt;
                        addend_reg <= ld_add;
                        state_reg  <= S_LD_RD;
                    end else if (ld_step_reg == 2'd2) begin
                        state_reg <= S_IDLE;
                    end else begin
                        ld_step_reg <= ld_step_reg + 2'd1;
                    end
                end
                S_LD_RD: begin
                    state_reg <= S_LD_WR;
                end
                S_LD_WR: begin
                    if (ld_step_reg == 2'd2) begin
                        state_reg <= S_IDLE;
                    end else begin
                        ld_step_reg <= ld_step_reg + 2'd1;
                        state_reg   <= S_LD_SEL;
                    end
                end
                S_WALK: begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd1) begin
                        a_lat_reg <= rdata_a;
                        b_lat_reg <= rdata_b;
                    end
                    if (sub_reg == 2'd3) begin
                        if (addr_reg == AW'(BIN_COUNT - 1)) begin
                            ret_reg   <= S_ZCHK;
                            state_reg <= S_DRAIN;
                        end else begin
                            addr_reg <= addr_reg + AW'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    li_reg    <= '0;
                    lj_reg    <= '0;
                    state_reg <= ret_reg;
                end
                S_ZCHK: begin
                    if (acc[ACC_NA] == '0 || acc[ACC_NB] == '0) begin
                        zflag_reg <= 1'b1;
                        lo_reg    <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        zflag_reg <= 1'b0;
                        state_reg <= S_NN;
                    end
                end
                S_NN, S_DSQ: begin
                    if (nn_last || sq_last) begin
                        ret_reg   <= (state_reg == S_NN) ? S_DSQ : S_SQ;
                        lo_reg    <= '0;
                        hi_reg    <= SIM_ONE;
                        state_reg <= S_DRAIN;
                    end else if (lj_reg == 3'(NORM_LIMBS - 1)) begin
                        lj_reg <= '0;
                        li_reg <= li_reg + 3'd1;
                    end else begin
                        lj_reg <= lj_reg + 3'd1;
                    end
                end
                S_SQ: begin
                    if (lo_reg == hi_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        mid_reg   <= mid;
                        ret_reg   <= S_T;
                        state_reg <= S_DRAIN;
                    end
                end
                S_T: begin
                    if (t_last) begin
                        ret_reg   <= S_CMP;
                        state_reg <= S_DRAIN;
                    end else if (lj_reg == 3'(NN_LIMBS - 1)) begin
                        lj_reg <= '0;
                        li_reg <= li_reg + 3'd1;
                    end else begin
                        lj_reg <= lj_reg + 3'd1;
                    end
                end
                S_CMP: begin
                    // keep mid when mid^2 * nn <= dot^2 * 2^32
                    if (acc[ACC_NB] <= lhs) begin
                        lo_reg <= mid_reg;
                    end else begin
                        hi_reg <= mid_reg - SIM_W'(1);
                    end
                    state_reg <= S_SQ;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_sim_reg   <= lo_reg;
                        m_zero_reg  <= zflag_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    bsc_ram #(.WIDTH(BIN_W), .DEPTH(BIN_COUNT)) u_bins_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (addr_reg),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (rdata_a)
    );

    bsc_ram #(.WIDTH(BIN_W), .DEPTH(BIN_COUNT)) u_bins_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (addr_reg),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (rdata_b)
    );

    bsc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_in   (mac_op),
        .acc     (acc)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_sim_reg};
    assign m_tuser  = m_zero_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_idle_no_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mac_op.valid)
        else $error("multiplier issued while idle");

    a_zero_sim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_zero_reg) |-> (m_sim_reg == '0))
        else $error("zero norm with nonzero similarity");

    a_sim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_sim_reg <= SIM_ONE))
        else $error("similarity above one");

    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQ || state_reg == S_CMP) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        (we_a || we_b) |-> (state_reg == S_INIT || state_reg == S_LD_WR ||
                            state_reg == S_WALK))
        else $error("bin write outside init, load or walk");

endmodule

[hw/rtl/bsc_ram.sv]
// ----------------------------------------------------------------------------
// bsc_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4003
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/bsc_mac.sv]
// ----------------------------------------------------------------------------
// bsc_mac: shared multiply-accumulate unit
// 32x32 multiplier, registered product, shifted add into one of four
// 256-bit accumulators.
// ----------------------------------------------------------------------------
module bsc_mac
    import bsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bsc_mac_op_t op_in,
    output bsc_acc_t    acc
);

    logic [2*LIMB_W-1:0]  prod_reg;
    logic                 pend_reg;
    logic [ACC_IDX_W-1:0] dst_reg;
    logic [SHIFT_W-1:0]   shift_reg;
    bsc_acc_t             acc_reg;
    logic [ACC_W-1:0]     addend;

    assign addend = ACC_W'(prod_reg) << {shift_reg, 5'd0};
    assign acc    = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= op_in.valid;
        end
        prod_reg  <= (2*LIMB_W)'(op_in.x) * (2*LIMB_W)'(op_in.y);
        dst_reg   <= op_in.dst;
        shift_reg <= op_in.shift;
        for (int k = 0; k < ACC_COUNT; k++) begin
            if (op_in.clr[k]) begin
                acc_reg[k] <= '0;
            end else if (pend_reg && dst_reg == ACC_IDX_W'(k)) begin
                acc_reg[k] <= acc_reg[k] + addend;
            end
        end
    end

endmodule

[tb/tb_binned_spectrum_cosine_similarity.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binned_spectrum_cosine_similarity: self-checking bench for the cosine block
// Peak loads and compute transfers go in from a queue with random gaps. A
// bin-exact predictor produces the Q16 cosine of every compute, and each
// result transfer is checked against it in order.
// ----------------------------------------------------------------------------
module tb_binned_spectrum_cosine_similarity
    import bsc_pkg::*;
();

    localparam int BIN_TOTAL  = 4003;
    localparam int FRAC_BITS  = 4;
    localparam int LAST_BIN_MZ = 32023;      // highest m/z that still lands in a bin
    localparam int QUIET_CYC  = 30;          // idle cycles before a register write
    localparam longint CYCLE_LIMIT = 40000000;
    localparam op_code_t OP_UNUSED = 2'd3;

    // queue entries: a stream item, a register write, or a hold until drained
    typedef enum logic [1:0] {ENT_PEAK, ENT_CFG, ENT_DRAIN} ent_kind_t;

    typedef struct {
        ent_kind_t   kind;
        op_code_t    op;
        logic [14:0] mz;
        logic [15:0] inten;
        logic        flank;
        logic        burst;    // no gaps while this is set
    } entry_t;

    typedef struct {
        logic [SIM_W-1:0] sim;
        logic             zero;
    } cosine_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [14:0] peak_mz, [30:15] peak_intensity
    logic [1:0]  s_tuser = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [16:0] similarity
    logic        m_tuser;        // [0] zero_norm

    entry_t  pending[$];
    cosine_t cosine_due[$];
    int      errors = 0;
    longint  cycles = 0;

    // predictor state: doubled bin sums and the flank register
    logic [31:0] spec_a [BIN_TOTAL];
    logic [31:0] spec_b [BIN_TOTAL];
    logic        flank_on = 1'b1;

    binned_spectrum_cosine_similarity #(
        .BIN_COUNT   (BIN_TOTAL),
        .MZ_FRAC_BITS(FRAC_BITS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // saturating add into one bin of A or B
    function automatic void bin_accum(bit to_b, int idx, logic [31:0] v);
        logic [32:0] s;
        s = {1'b0, (to_b ? spec_b[idx] : spec_a[idx])} + {1'b0, v};
        if (s[32]) s = 33'h0_FFFF_FFFF;
        if (to_b) spec_b[idx] = s[31:0];
        else      spec_a[idx] = s[31:0];
    endfunction

    // applies one accepted transfer; a compute queues the expected cosine
    function automatic void apply_peak_or_cosine(op_code_t op, logic [14:0] mz,
                                                 logic [15:0] inten);
        int          idx;
        logic [511:0] dot, na, nb, nn, lhs, trial;
        logic [16:0] lo, hi, mid;
        cosine_t     c;
        if (op == OP_LOAD_A || op == OP_LOAD_B) begin
            idx = (int'(mz) * 2) >> FRAC_BITS;
            if (idx >= BIN_TOTAL) return;          // beyond last bin: dropped with flanks
            bin_accum(op == OP_LOAD_B, idx, {15'd0, inten, 1'b0});
            if (flank_on) begin
                if (idx >= 1) bin_accum(op == OP_LOAD_B, idx - 1, {16'd0, inten});
                if (idx + 1 < BIN_TOTAL) bin_accum(op == OP_LOAD_B, idx + 1, {16'd0, inten});
            end
        end else if (op == OP_COMPUTE) begin
            dot = '0; na = '0; nb = '0;
            for (int i = 0; i < BIN_TOTAL; i++) begin
                dot += 512'(spec_a[i]) * 512'(spec_b[i]);
                na  += 512'(spec_a[i]) * 512'(spec_a[i]);
                nb  += 512'(spec_b[i]) * 512'(spec_b[i]);
                spec_a[i] = '0;
                spec_b[i] = '0;
            end
            if (na == 0 || nb == 0) begin
                c.sim = '0;
                c.zero = 1'b1;
            end else begin
                // largest s with s^2 * na * nb <= 2^32 * dot^2
                nn = na * nb;
                lhs = (dot * dot) << 32;
                lo = 0;
                hi = 17'd65536;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 1) / 2;
                    trial = 512'(mid) * 512'(mid) * nn;
                    if (trial <= lhs) lo = mid;
                    else hi = mid - 1;
                end
                c.sim = lo;
                c.zero = 1'b0;
            end
            cosine_due.insert(cosine_due.size(), c);
        end
        // unused operation: ignored
    endfunction

    // ------------------------------------------------------------------
    // driver: feeds the input stream and register writes from pending
    // ------------------------------------------------------------------
    int      drv_gap = 0;
    int      quiet = 0;

    always @(posedge aclk) begin
        logic        nv, nwr, nwd;
        logic [31:0] nd;
        logic [1:0]  nu;
        entry_t      e;
        nv = s_tvalid; nwr = 1'b0; nwd = cfg_wr_data; nd = s_tdata; nu = s_tuser;
        if (!aresetn) begin
            nv = 1'b0;
            drv_gap = 0;
            quiet = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_peak_or_cosine(op_code_t'(s_tuser), s_tdata[14:0], s_tdata[30:15]);
                nv = 1'b0;
            end
            quiet = (s_tvalid || cosine_due.size() != 0) ? 0 : quiet + 1;
            if (!nv) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending.size() != 0) begin
                    e = pending[0];
                    case (e.kind)
                        ENT_PEAK: begin
                            nv = 1'b1;
                            nd = {1'b0, e.inten, e.mz};
                            nu = e.op;
                            drv_gap = e.burst ? 0 : gap_len();
                            void'(pending.pop_front());
                        end
                        ENT_CFG: begin
                            // only once the block has settled after the last transfer
                            if (quiet >= QUIET_CYC && s_tready) begin
                                nwr = 1'b1;
                                nwd = e.flank;
                                flank_on = e.flank;
                                void'(pending.pop_front());
                            end
                        end
                        default: begin
                            if (quiet >= QUIET_CYC) void'(pending.pop_front());
                        end
                    endcase
                end
            end
        end
        s_tvalid    <= nv;
        s_tdata     <= nd;
        s_tuser     <= nu;
        cfg_wr_en   <= nwr;
        cfg_wr_data <= nwd;
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, checks each result transfer
    // ------------------------------------------------------------------
    int mon_stall = 0;

    always @(posedge aclk) begin
        logic    nr;
        cosine_t c;
        if (!aresetn) begin
            nr = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (cosine_due.size() == 0) begin
                    $display("%0t: unexpected result sim=%0d zero=%0d",
                             $time, m_tdata[16:0], m_tuser);
                    errors++;
                end else begin
                    c = cosine_due.pop_front();
                    if (m_tdata[16:0] !== c.sim) begin
                        $display("%0t: similarity expected %0d actual %0d",
                                 $time, c.sim, m_tdata[16:0]);
                        errors++;
                    end
                    if (m_tuser !== c.zero) begin
                        $display("%0t: zero_norm expected %0d actual %0d",
                                 $time, c.zero, m_tuser);
                        errors++;
                    end
                end
                mon_stall = gap_len();
            end else if (mon_stall == 0 && $urandom_range(0, 15) == 0) begin
                mon_stall = gap_len();
            end
            if (mon_stall > 0) begin
                mon_stall--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
        end
        m_tready <= nr;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[binned_spectrum_cosine_similarity] ERROR");
            $finish;
        end
    end

    function automatic void put_peak(op_code_t op, int mz, int inten, logic burst);
        entry_t e;
        e.kind = ENT_PEAK; e.op = op; e.mz = mz[14:0]; e.inten = inten[15:0];
        e.flank = 1'b0; e.burst = burst;
        pending.insert(pending.size(), e);
    endfunction

    function automatic void put_mark(ent_kind_t k, logic flank);
        entry_t e;
        e.kind = k; e.op = OP_UNUSED; e.mz = '0; e.inten = '0;
        e.flank = flank; e.burst = 1'b0;
        pending.insert(pending.size(), e);
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int n_items, n_loads, base, mz, inten;
        int pool[8];
        op_code_t op;
        logic burst;

        for (int i = 0; i < BIN_TOTAL; i++) begin
            spec_a[i] = '0;
            spec_b[i] = '0;
        end

        // directed: flank spreading at its reset value
        put_mark(ENT_CFG, 1'b1);
        put_peak(OP_LOAD_A, 0, 65535, 1'b0);           // lowest bin, no left flank
        put_peak(OP_LOAD_B, 0, 65535, 1'b0);
        put_peak(OP_COMPUTE, 0, 0, 1'b0);              // identical spectra
        put_peak(OP_COMPUTE, 32767, 65535, 1'b0);      // both empty
        put_peak(OP_LOAD_A, LAST_BIN_MZ, 40000, 1'b0); // last bin, no right flank
        put_peak(OP_LOAD_A, LAST_BIN_MZ + 1, 1234, 1'b0); // just beyond: dropped
        put_peak(OP_LOAD_B, 32767, 65535, 1'b0);       // beyond range: dropped
        put_peak(OP_COMPUTE, 0, 0, 1'b0);              // B empty
        put_peak(OP_LOAD_A, 100, 0, 1'b0);             // zero intensity
        put_peak(OP_LOAD_B, 100, 500, 1'b0);
        put_peak(OP_UNUSED, 16383, 21845, 1'b0);       // ignored
        put_peak(OP_UNUSED, 0, 43690, 1'b0);
        put_peak(OP_LOAD_A, 120, 300, 1'b0);
        put_peak(OP_LOAD_B, 128, 300, 1'b0);           // overlaps only through flanks
        put_peak(OP_COMPUTE, 0, 0, 1'b0);
        put_mark(ENT_DRAIN, 1'b0);

        // flank spreading off
        put_mark(ENT_CFG, 1'b0);
        put_peak(OP_LOAD_A, 0, 65535, 1'b0);
        put_peak(OP_LOAD_A, LAST_BIN_MZ, 65535, 1'b0);
        put_peak(OP_LOAD_B, 8, 777, 1'b0);             // neighbor bin, no overlap
        put_peak(OP_COMPUTE, 0, 0, 1'b0);
        put_peak(OP_LOAD_A, 5000, 1, 1'b0);
        put_peak(OP_LOAD_B, 5000, 65535, 1'b0);
        put_peak(OP_COMPUTE, 0, 0, 1'b0);
        put_mark(ENT_CFG, 1'b1);
        n_items = 23;

        // random rounds: peaks around a small pool of m/z values, then a compute
        while (n_items < 1850) begin
            if ($urandom_range(0, 5) == 0) put_mark(ENT_CFG, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0) put_mark(ENT_DRAIN, 1'b0);
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 8; k++) pool[k] = $urandom_range(0, LAST_BIN_MZ);
            n_loads = $urandom_range(3, 45);
            for (int k = 0; k < n_loads; k++) begin
                base = $urandom_range(0, 9);
                if (base < 7) begin
                    mz = pool[$urandom_range(0, 7)] + $urandom_range(0, 20) - 10;
                    if (mz < 0) mz = 0;
                    if (mz > 32767) mz = 32767;
                end else begin
                    mz = $urandom_range(0, 32767);
                end
                inten = ($urandom_range(0, 7) == 0) ? 65535 - $urandom_range(0, 3)
                                                    : $urandom_range(0, 65535);
                op = ($urandom_range(0, 39) == 0) ? OP_UNUSED
                                                  : op_code_t'($urandom_range(0, 1));
                put_peak(op, mz, inten, burst);
                n_items++;
            end
            put_peak(OP_COMPUTE, $urandom_range(0, 32767), $urandom_range(0, 65535), burst);
            n_items++;
        end

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending.size() == 0 && !s_tvalid && cosine_due.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("[binned_spectrum_cosine_similarity] OK");
        else
            $display("[binned_spectrum_cosine_similarity] ERROR");
        $finish;
    end

endmodule
